### src/radial_vignette_pixel_scaler_assert.svh
// assertion macros for the radial vignette pixel scaler
// expects a clock named aclk and an active-low reset named aresetn in scope
`ifndef RADIAL_VIGNETTE_PIXEL_SCALER_ASSERT_SVH
`define RADIAL_VIGNETTE_PIXEL_SCALER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// checked only while out of reset
`define RVPS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("rvps assertion failed");
// checked at every edge, reset included
`define RVPS_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("rvps assertion failed");
`else
`define RVPS_ASSERT(lbl, prop)
`define RVPS_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

### src/rvps_pkg.sv
// shared types and constants of the radial vignette pixel scaler
// no dependencies
`timescale 1ns / 1ps
package rvps_pkg;

    localparam int COORD_BITS      = 12;
    // power of two, 64 to 4096
    localparam int FALLOFF_ENTRIES = 1024;
    localparam int IDX_BITS        = $clog2(FALLOFF_ENTRIES);

    localparam int SIZE_BITS   = 13;
    localparam int STR_BITS    = 11;
    localparam int RECIP_BITS  = 32;
    localparam int Q10_BITS    = 11;
    localparam int PIX_BITS    = 8;

    localparam int EXT_BITS = (COORD_BITS + 1 > SIZE_BITS) ? COORD_BITS + 1 : SIZE_BITS;
    localparam int DX_BITS  = EXT_BITS + 1;
    localparam int SQ_BITS  = 2 * EXT_BITS;
    localparam int SUM_BITS = SQ_BITS + 1;
    localparam int PROD_BITS = SUM_BITS + RECIP_BITS;

    localparam logic [EXT_BITS-1:0] COORD_LIMIT = EXT_BITS'(1) << COORD_BITS;
    localparam logic [Q10_BITS-1:0] Q10_ONE     = Q10_BITS'(1024);

    localparam int REG_ADDR_BITS = 4;

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_STRENGTH     = 2'd2,
        REG_INV_CORNER   = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [SIZE_BITS-1:0]  frame_width;
        logic [SIZE_BITS-1:0]  frame_height;
        logic [STR_BITS-1:0]   strength_q10;
        logic [RECIP_BITS-1:0] inverse_corner_distance;
    } cfg_t;

    // stage strobes from controller to datapath, at most one high
    typedef struct packed {
        logic capture;
        logic square;
        logic sum;
        logic mult;
        logic index;
        logic rom;
        logic blend;
        logic scale;
    } cmd_t;

endpackage

### src/rvps_regs.sv
// apb register file: frame size, strength and inverse corner distance
// depends on rvps_pkg
`timescale 1ns / 1ps
module rvps_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rvps_pkg::REG_ADDR_BITS-1:0] paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output rvps_pkg::cfg_t                     cfg
);
    import rvps_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    reg_index_t sel;

    assign sel = reg_index_t'(paddr[3:2]);

    always_comb begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite) begin
            case (sel)
                REG_FRAME_WIDTH:  cfg_next.frame_width  = pwdata[SIZE_BITS-1:0];
                REG_FRAME_HEIGHT: cfg_next.frame_height = pwdata[SIZE_BITS-1:0];
                REG_STRENGTH:     cfg_next.strength_q10 = pwdata[STR_BITS-1:0];
                REG_INV_CORNER:   cfg_next.inverse_corner_distance = pwdata;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_width             <= SIZE_BITS'(640);
            cfg_reg.frame_height            <= SIZE_BITS'(480);
            cfg_reg.strength_q10            <= STR_BITS'(1024);
            cfg_reg.inverse_corner_distance <= RECIP_BITS'(6990);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (sel)
            REG_FRAME_WIDTH:  prdata = {{(32-SIZE_BITS){1'b0}}, cfg_reg.frame_width};
            REG_FRAME_HEIGHT: prdata = {{(32-SIZE_BITS){1'b0}}, cfg_reg.frame_height};
            REG_STRENGTH:     prdata = {{(32-STR_BITS){1'b0}}, cfg_reg.strength_q10};
            REG_INV_CORNER:   prdata = cfg_reg.inverse_corner_distance;
            default:          prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

### src/rvps_ctrl.sv
// sequencer: walks one word through the datapath stages, owns output valid
// depends on rvps_pkg
`timescale 1ns / 1ps
module rvps_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    output rvps_pkg::cmd_t cmd
);
    import rvps_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SQUARE, ST_SUM, ST_MULT, ST_INDEX, ST_ROM, ST_BLEND, ST_SCALE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;

    always_comb begin
        cmd         = '0;
        cmd.capture = (state_reg == ST_IDLE) && s_valid;
        cmd.square  = (state_reg == ST_SQUARE);
        cmd.sum     = (state_reg == ST_SUM);
        cmd.mult    = (state_reg == ST_MULT);
        cmd.index   = (state_reg == ST_INDEX);
        cmd.rom     = (state_reg == ST_ROM);
        cmd.blend   = (state_reg == ST_BLEND);
        // output slot free or emptied this cycle
        cmd.scale   = (state_reg == ST_SCALE) && (!m_valid_reg || m_ready);
    end

    always_comb begin
        case (state_reg)
            ST_IDLE:   state_next = s_valid ? ST_SQUARE : ST_IDLE;
            ST_SQUARE: state_next = ST_SUM;
            ST_SUM:    state_next = ST_MULT;
            ST_MULT:   state_next = ST_INDEX;
            ST_INDEX:  state_next = ST_ROM;
            ST_ROM:    state_next = ST_BLEND;
            ST_BLEND:  state_next = ST_SCALE;
            ST_SCALE:  state_next = cmd.scale ? ST_IDLE : ST_SCALE;
            default:   state_next = ST_IDLE;
        endcase

        if (cmd.scale)
            m_valid_next = 1'b1;
        else if (m_ready)
            m_valid_next = 1'b0;
        else
            m_valid_next = m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

### src/rvps_datapath.sv
// datapath: position counters, radial distance, falloff rom, blend and scaling
// depends on rvps_pkg
`timescale 1ns / 1ps
module rvps_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  rvps_pkg::cmd_t                cmd,
    input  rvps_pkg::cfg_t                cfg,
    input  logic [rvps_pkg::PIX_BITS-1:0] red_in,
    input  logic [rvps_pkg::PIX_BITS-1:0] green_in,
    input  logic [rvps_pkg::PIX_BITS-1:0] blue_in,
    input  logic [rvps_pkg::PIX_BITS-1:0] alpha_in,
    output logic [rvps_pkg::PIX_BITS-1:0] red_out,
    output logic [rvps_pkg::PIX_BITS-1:0] green_out,
    output logic [rvps_pkg::PIX_BITS-1:0] blue_out,
    output logic [rvps_pkg::PIX_BITS-1:0] alpha_out,
    output logic                          frame_end
);
    import rvps_pkg::*;

    typedef logic [Q10_BITS-1:0] falloff_rom_t [FALLOFF_ENTRIES];

    // true when r - 0.5 <= 1024 * (i / N)^0.75
    function automatic logic round_reaches(int unsigned r, int unsigned i);
        logic [127:0] o;
        logic [127:0] a;
        logic [127:0] c;
        logic [127:0] n3;
        o  = 128'(r) * 128'(2) - 128'(1);
        a  = o * o * o * o;
        c  = 128'(i) * 128'(i) * 128'(i);
        n3 = 128'(FALLOFF_ENTRIES) * 128'(FALLOFF_ENTRIES) * 128'(FALLOFF_ENTRIES);
        return (a * n3) <= (c << 44);
    endfunction

    function automatic falloff_rom_t build_falloff_rom();
        falloff_rom_t rom;
        int unsigned  lo;
        int unsigned  hi;
        int unsigned  mid;
        for (int i = 0; i < FALLOFF_ENTRIES; i++) begin
            lo = 0;
            hi = 1024;
            while (lo < hi) begin
                mid = (lo + hi + 1) >> 1;
                if (round_reaches(mid, i))
                    lo = mid;
                else
                    hi = mid - 1;
            end
            rom[i] = Q10_BITS'(1024 - lo);
        end
        return rom;
    endfunction

    localparam falloff_rom_t FALLOFF_ROM = build_falloff_rom();

    logic [COORD_BITS-1:0] column_position_reg, column_position_next;
    logic [COORD_BITS-1:0] row_position_reg, row_position_next;

    logic [PIX_BITS-1:0]     red_reg, green_reg, blue_reg, alpha_reg;
    logic                    last_reg;
    logic signed [DX_BITS-1:0] dx2_reg, dy2_reg;
    logic [SQ_BITS-1:0]      sqx_reg, sqy_reg;
    logic [SUM_BITS-1:0]     sum_reg;
    logic [PROD_BITS-1:0]    prod_reg;
    logic [IDX_BITS-1:0]     idx_reg;
    logic [Q10_BITS-1:0]     v_reg;
    logic [Q10_BITS-1:0]     f_reg;

    logic [PIX_BITS-1:0] red_out_reg, green_out_reg, blue_out_reg, alpha_out_reg;
    logic                frame_end_reg;

    logic [EXT_BITS-1:0] w_eff, h_eff;
    logic [EXT_BITS-1:0] col_inc, row_inc;
    logic                row_end, frame_last;
    logic signed [DX_BITS:0] dx2_wide, dy2_wide;
    logic signed [2*DX_BITS-1:0] sqx_full, sqy_full;
    logic [Q10_BITS-1:0] s_sat;
    logic [2*Q10_BITS-1:0] atten;
    logic [IDX_BITS-1:0] idx_next;
    logic [Q10_BITS-1:0] f_next;

    // oversized frames clamp to the counter range
    assign w_eff = (EXT_BITS'(cfg.frame_width) > COORD_LIMIT)
                   ? COORD_LIMIT : EXT_BITS'(cfg.frame_width);
    assign h_eff = (EXT_BITS'(cfg.frame_height) > COORD_LIMIT)
                   ? COORD_LIMIT : EXT_BITS'(cfg.frame_height);

    assign col_inc    = EXT_BITS'(column_position_reg) + EXT_BITS'(1);
    assign row_inc    = EXT_BITS'(row_position_reg) + EXT_BITS'(1);
    assign row_end    = (col_inc >= w_eff);
    assign frame_last = row_end && (row_inc >= h_eff);

    assign dx2_wide = $signed({2'b00, column_position_reg, 1'b0})
                    - $signed({1'b0, w_eff});
    assign dy2_wide = $signed({2'b00, row_position_reg, 1'b0})
                    - $signed({1'b0, h_eff});

    always_comb begin
        if (row_end) begin
            column_position_next = '0;
            row_position_next    = frame_last ? '0 : row_inc[COORD_BITS-1:0];
        end else begin
            column_position_next = col_inc[COORD_BITS-1:0];
            row_position_next    = row_position_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_position_reg <= '0;
            row_position_reg    <= '0;
        end else if (cmd.capture) begin
            column_position_reg <= column_position_next;
            row_position_reg    <= row_position_next;
        end
    end

    assign sqx_full = dx2_reg * dx2_reg;
    assign sqy_full = dy2_reg * dy2_reg;

    // index is p >> (32 - IDX_BITS), clamped to the last entry
    assign idx_next = (prod_reg[PROD_BITS-1:RECIP_BITS] != '0)
                      ? IDX_BITS'(FALLOFF_ENTRIES - 1)
                      : prod_reg[RECIP_BITS-1:RECIP_BITS-IDX_BITS];

    // atten is at most 2^20, so its top bit is always clear
    assign s_sat  = (cfg.strength_q10 > Q10_ONE) ? Q10_ONE : cfg.strength_q10;
    assign atten  = (Q10_ONE - v_reg) * s_sat;
    assign f_next = Q10_ONE - atten[2*Q10_BITS-2:10];

    function automatic logic [PIX_BITS-1:0] scale_chan(logic [PIX_BITS-1:0] c,
                                                     logic [Q10_BITS-1:0] f);
        logic [PIX_BITS+Q10_BITS-1:0] prod;
        logic [PIX_BITS+Q10_BITS-11:0] shifted;
        prod    = c * f;
        shifted = prod[PIX_BITS+Q10_BITS-1:10];
        return (shifted > (PIX_BITS+Q10_BITS-10)'(255)) ? PIX_BITS'(255)
                                                        : shifted[PIX_BITS-1:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            red_reg   <= red_in;
            green_reg <= green_in;
            blue_reg  <= blue_in;
            alpha_reg <= alpha_in;
            last_reg  <= frame_last;
            dx2_reg   <= dx2_wide[DX_BITS-1:0];
            dy2_reg   <= dy2_wide[DX_BITS-1:0];
        end
        if (cmd.square) begin
            sqx_reg <= sqx_full[SQ_BITS-1:0];
            sqy_reg <= sqy_full[SQ_BITS-1:0];
        end
        if (cmd.sum)
            sum_reg <= SUM_BITS'(sqx_reg) + SUM_BITS'(sqy_reg);
        if (cmd.mult)
            prod_reg <= sum_reg * cfg.inverse_corner_distance;
        if (cmd.index)
            idx_reg <= idx_next;
        if (cmd.rom)
            v_reg <= FALLOFF_ROM[idx_reg];
        if (cmd.blend)
            f_reg <= f_next;
        if (cmd.scale) begin
            red_out_reg   <= scale_chan(red_reg, f_reg);
            green_out_reg <= scale_chan(green_reg, f_reg);
            blue_out_reg  <= scale_chan(blue_reg, f_reg);
            alpha_out_reg <= alpha_reg;
            frame_end_reg <= last_reg;
        end
    end

    assign red_out   = red_out_reg;
    assign green_out = green_out_reg;
    assign blue_out  = blue_out_reg;
    assign alpha_out = alpha_out_reg;
    assign frame_end = frame_end_reg;

endmodule

### src/radial_vignette_pixel_scaler.sv
// radial vignette pixel scaler, top level
// depends on rvps_pkg, rvps_regs, rvps_ctrl, rvps_datapath and the assert header
// usage
//   pixels enter on the s_ channel in raster order, one rgba word per handshake;
//   each word leaves on the m_ channel with red, green and blue scaled by a
//   radial falloff factor, alpha copied and frame_end set on the last pixel
// sequencing
//   a word is accepted only while the single sequencer is idle; the sequencer
//   walks it through square, sum, 27x32 multiply, index clamp, registered rom
//   read, blend and scale, and m_valid rises as the scale step loads the output
//   register; the next word is taken only once the sequencer is back in idle
// stalls
//   the result sits in an output register; while it waits the next word is
//   accepted and worked on, and the sequencer holds in its scale step until
//   the output register is taken
// reset
//   aresetn low clears the column and row counters, drops m_valid and loads
//   the register defaults (640 x 480, full strength, 6990); no clearing pass
// configuration
//   apb, register i at byte address 4*i, pready always high, write only when idle
`timescale 1ns / 1ps
`include "radial_vignette_pixel_scaler_assert.svh"
module radial_vignette_pixel_scaler (
    input  logic                               aclk,
    input  logic                               aresetn,
    // apb configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rvps_pkg::REG_ADDR_BITS-1:0] paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    // pixel input
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [rvps_pkg::PIX_BITS-1:0]      s_red_in,
    input  logic [rvps_pkg::PIX_BITS-1:0]      s_green_in,
    input  logic [rvps_pkg::PIX_BITS-1:0]      s_blue_in,
    input  logic [rvps_pkg::PIX_BITS-1:0]      s_alpha_in,
    // pixel output
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [rvps_pkg::PIX_BITS-1:0]      m_red_out,
    output logic [rvps_pkg::PIX_BITS-1:0]      m_green_out,
    output logic [rvps_pkg::PIX_BITS-1:0]      m_blue_out,
    output logic [rvps_pkg::PIX_BITS-1:0]      m_alpha_out,
    output logic                               m_frame_end
);
    import rvps_pkg::*;

    cfg_t cfg;
    cmd_t cmd;

    // register accesses complete without wait states
    assign pready = 1'b1;

    rvps_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // sequencer: one word in flight, output valid held here
    rvps_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // counters, distance math, falloff rom and output register
    rvps_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .cfg       (cfg),
        .red_in    (s_red_in),
        .green_in  (s_green_in),
        .blue_in   (s_blue_in),
        .alpha_in  (s_alpha_in),
        .red_out   (m_red_out),
        .green_out (m_green_out),
        .blue_out  (m_blue_out),
        .alpha_out (m_alpha_out),
        .frame_end (m_frame_end)
    );

    // a taken word keeps the input closed while it is being worked on
    `RVPS_ASSERT(a_busy_after_accept, s_valid && s_ready |=> !s_ready)
    // stage strobes never overlap
    `RVPS_ASSERT(a_one_stage, $onehot0(cmd))
    // reset empties the output register
    `RVPS_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_valid)
    // a new result is loaded only while the input is closed
    `RVPS_ASSERT(a_load_busy, cmd.scale |-> !s_ready)

endmodule
